[src/split_tone_pixel_unit_macros.svh]
// Assertion macros for the split tone pixel unit.
// Used by the top level; relies on the including module's clk and rst_n.
`ifndef SPLIT_TONE_PIXEL_UNIT_MACROS_SVH
`define SPLIT_TONE_PIXEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPU_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPU_ASSERT(label, prop, msg)
`define SPU_ASSERT_ANY(label, prop, msg)
`endif
`endif

[src/spu_pkg.sv]
// Shared constants, types and rounding helper for the split tone pixel unit.
// No dependencies.
`default_nettype none
package spu_pkg;

    localparam int PIX_W      = 16;
    localparam int GAIN_W     = 13;
    localparam int BAL_W      = 14;
    localparam int HUE_W      = 16;
    localparam int Q16_W      = 17;
    localparam int DIV_NW     = 36;
    localparam int DIV_DW     = 20;
    localparam int DIV_QW     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WORD_W     = 4 * PIX_W;

    localparam int FRONT_LAT  = 4;
    localparam int BACK_LAT   = 6;
    localparam int PIPE_LAT   = FRONT_LAT + DIV_QW + BACK_LAT;

    localparam logic [CFG_IDX_W-1:0] CFG_HL_HUE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HL_STR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SH_HUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SH_STR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 3'd5;

    localparam logic [HUE_W-1:0]  HL_HUE_RST  = 16'd7282;
    localparam logic [HUE_W-1:0]  SH_HUE_RST  = 16'd40050;
    localparam logic [GAIN_W-1:0] GAIN_ONE    = 13'd4096;

    localparam logic [15:0] LUMA_KR    = 16'd13933;
    localparam logic [15:0] LUMA_KG    = 16'd46871;
    localparam logic [15:0] LUMA_KB    = 16'd4732;
    localparam logic [15:0] BAL_SCALE  = 16'd26214;
    localparam logic [15:0] PIVOT_MID  = 16'd32768;
    localparam logic [15:0] PIVOT_MIN  = 16'd6554;
    localparam logic [15:0] PIVOT_MAX  = 16'd58982;
    localparam logic [15:0] THIRD_TURN = 16'd21845;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] light;
        logic [Q16_W-1:0] weight;
        logic             gray;
    } spu_pay_t;

    typedef struct packed {
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } spu_divop_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hl_hue;
        logic [GAIN_W-1:0] hl_str;
        logic [HUE_W-1:0]  sh_hue;
        logic [GAIN_W-1:0] sh_str;
        logic [GAIN_W-1:0] mix;
    } spu_cfg_t;

    typedef enum logic [1:0] {
        SEL_RAMP = 2'd0,
        SEL_Q    = 2'd1,
        SEL_P    = 2'd2
    } spu_sel_t;

    // signed shift right by sh, rounding half away from zero
    function automatic logic signed [49:0] rnd_shift(input logic signed [49:0] x,
                                                     input int sh);
        logic [49:0] mag;
        logic [49:0] r;
        mag = x[49] ? 50'(-x) : 50'(x);
        r   = (mag + (50'd1 << (sh - 1))) >> sh;
        return x[49] ? -$signed(r) : $signed(r);
    endfunction

endpackage
`default_nettype wire

[src/spu_front.sv]
// Front stages: luma, smoothstep weight, HSL prep and divider operands.
// Depends on spu_pkg.
`default_nettype none
module spu_front import spu_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [PIX_W-1:0] pivot,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] alpha,
    output spu_pay_t         pay,
    output spu_divop_t       hue_op,
    output spu_divop_t       sat_op
);

    logic [PIX_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg, s1_alpha_reg;
    logic [PIX_W-1:0] s1_max_reg, s1_min_reg;
    logic [31:0]      s1_lsum_reg;
    logic [PIX_W-1:0] mx, mn;
    logic [31:0]      lsum;

    spu_pay_t          s2_pay_reg, s3_pay_reg;
    logic [Q16_W-1:0]  s2_t_reg, s3_t_reg, s3_t2_reg;
    logic [PIX_W-1:0]  s2_d_reg, s3_d_reg;
    logic [16:0]       s2_den_reg, s3_den_reg;
    logic [18:0]       s2_num_reg, s3_num_reg;

    logic [Q16_W-1:0]  luma;
    logic signed [19:0] offs;
    logic [Q16_W-1:0]  t;
    logic [16:0]       sum;
    logic [PIX_W-1:0]  d;
    logic [16:0]       den;
    logic signed [20:0] num;
    logic [20:0]       d6;
    spu_pay_t          s2_pay;

    logic [Q16_W-1:0]  t2;
    logic [17:0]       fac;
    logic [Q16_W-1:0]  w;
    spu_pay_t          s4_pay;
    spu_divop_t        s4_hue_op, s4_sat_op;

    // stage 1: min/max and luma sum
    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        lsum = ({16'b0, red} * {16'b0, LUMA_KR}) + ({16'b0, green} * {16'b0, LUMA_KG})
             + ({16'b0, blue} * {16'b0, LUMA_KB});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_alpha_reg <= alpha;
            s1_max_reg   <= mx;
            s1_min_reg   <= mn;
            s1_lsum_reg  <= lsum;
        end
    end

    // stage 2: smoothstep input, lightness, hue numerator
    always_comb
    begin
        luma = 17'((33'(s1_lsum_reg) + 33'd32768) >> 16);
        offs = $signed({3'b0, luma}) - $signed({4'b0, pivot}) + 20'sd16384;
        if (offs < 0)
            t = '0;
        else if (offs >= 20'sd32768)
            t = 17'd65536;
        else
            t = {offs[15:0], 1'b0};
        sum = {1'b0, s1_max_reg} + {1'b0, s1_min_reg};
        d   = s1_max_reg - s1_min_reg;
        den = (sum > 17'd65536) ? 17'(18'd131072 - {1'b0, sum}) : sum;
        d6  = {5'b0, d} * 21'd6;
        if (s1_max_reg == s1_red_reg)
        begin
            num = $signed({5'b0, s1_green_reg}) - $signed({5'b0, s1_blue_reg});
            if (s1_green_reg < s1_blue_reg)
                num = num + $signed(d6);
        end
        else if (s1_max_reg == s1_green_reg)
            num = $signed({5'b0, s1_blue_reg}) - $signed({5'b0, s1_red_reg})
                + $signed({4'b0, d, 1'b0});
        else
            num = $signed({5'b0, s1_red_reg}) - $signed({5'b0, s1_green_reg})
                + $signed({3'b0, d, 2'b0});
        s2_pay.red    = s1_red_reg;
        s2_pay.green  = s1_green_reg;
        s2_pay.blue   = s1_blue_reg;
        s2_pay.alpha  = s1_alpha_reg;
        s2_pay.light  = sum[16:1];
        s2_pay.weight = '0;
        s2_pay.gray   = (d == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pay_reg <= s2_pay;
            s2_t_reg   <= t;
            s2_d_reg   <= d;
            s2_den_reg <= den;
            s2_num_reg <= num[18:0];
        end
    end

    // stage 3: t squared
    assign t2 = 17'((34'(s2_t_reg) * 34'(s2_t_reg) + 34'd32768) >> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pay_reg <= s2_pay_reg;
            s3_t_reg   <= s2_t_reg;
            s3_t2_reg  <= t2;
            s3_d_reg   <= s2_d_reg;
            s3_den_reg <= s2_den_reg;
            s3_num_reg <= s2_num_reg;
        end
    end

    // stage 4: weight and divider operands
    assign fac = 18'd196608 - {s3_t_reg, 1'b0};
    assign w   = 17'((35'(s3_t2_reg) * 35'(fac) + 35'd32768) >> 16);

    always_comb
    begin
        s4_pay         = s3_pay_reg;
        s4_pay.weight  = w;
        s4_hue_op.num  = {1'b0, s3_num_reg, 16'b0} + (36'(s3_d_reg) * 36'd3);
        s4_hue_op.den  = 20'(s3_d_reg) * 20'd6;
        s4_sat_op.num  = 36'({s3_d_reg, 16'b0});
        s4_sat_op.den  = 20'(s3_den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay    <= s4_pay;
            hue_op <= s4_hue_op;
            sat_op <= s4_sat_op;
        end
    end

endmodule
`default_nettype wire

[src/spu_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on spu_pkg; quotient must fit DIV_QW bits.
`default_nettype none
module spu_div import spu_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  spu_divop_t        op,
    output logic [DIV_QW-1:0] quo
);

    logic [DIV_NW-1:0] rem_reg  [1:DIV_QW];
    logic [DIV_DW-1:0] dsr_reg  [1:DIV_QW];
    logic [DIV_QW-1:0] q_reg    [1:DIV_QW];
    logic [DIV_NW-1:0] rem_next [1:DIV_QW];
    logic [DIV_QW-1:0] q_next   [1:DIV_QW];

    for (genvar k = 0; k < DIV_QW; k++)
    begin : g_stage
        logic [DIV_NW-1:0] r_in;
        logic [DIV_DW-1:0] d_in;
        logic [DIV_QW-1:0] q_in;
        logic [DIV_NW:0]   shd;
        logic              ge;
        if (k == 0)
        begin : g_first
            assign r_in = op.num;
            assign d_in = op.den;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k];
            assign d_in = dsr_reg[k];
            assign q_in = q_reg[k];
        end
        assign shd = (DIV_NW+1)'(d_in) << (DIV_QW - 1 - k);
        assign ge  = ({1'b0, r_in} >= shd);
        assign rem_next[k+1] = ge ? (r_in - shd[DIV_NW-1:0]) : r_in;
        assign q_next[k+1]   = q_in | (DIV_QW'(ge) << (DIV_QW - 1 - k));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= DIV_QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
            dsr_reg[1] <= op.den;
            for (int k = 2; k <= DIV_QW; k++)
                dsr_reg[k] <= dsr_reg[k-1];
        end
    end

    assign quo = q_reg[DIV_QW];

endmodule
`default_nettype wire

[src/spu_back.sv]
// Back stages: hue shift, HSL to RGB, blend and saturate.
// Depends on spu_pkg.
`default_nettype none
module spu_back import spu_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  spu_cfg_t          cfg,
    input  spu_pay_t          pay,
    input  logic [DIV_QW-1:0] hue_q,
    input  logic [DIV_QW-1:0] sat_q,
    output logic [PIX_W-1:0]  red,
    output logic [PIX_W-1:0]  green,
    output logic [PIX_W-1:0]  blue,
    output logic [PIX_W-1:0]  alpha
);

    function automatic logic signed [16:0] arc_delta(input logic [15:0] hue,
                                                     input logic [15:0] target);
        logic signed [17:0] diff;
        logic signed [17:0] adj;
        diff = $signed({2'b00, target}) - $signed({2'b00, hue});
        if (diff > 18'sd32768)
            adj = diff - 18'sd65536;
        else if (diff < -18'sd32768)
            adj = diff + 18'sd65536;
        else
            adj = diff;
        return adj[16:0];
    endfunction

    // stage E
    spu_pay_t           e_pay_reg;
    logic [HUE_W-1:0]   e_hue_reg;
    logic [DIV_QW-1:0]  e_s16_reg;
    logic signed [30:0] e_m1_reg, e_m2_reg;
    logic [16:0]        e_ls_reg;
    spu_pay_t           e_pay;
    logic [33:0]        ls_full;

    always_comb
    begin
        e_pay      = pay;
        e_pay.gray = pay.gray || (sat_q == '0);
        ls_full    = (34'(pay.light) * 34'(sat_q)) + 34'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_pay_reg <= e_pay;
            e_hue_reg <= hue_q[HUE_W-1:0];
            e_s16_reg <= sat_q;
            e_m1_reg  <= arc_delta(hue_q[HUE_W-1:0], cfg.hl_hue) * $signed({1'b0, cfg.hl_str});
            e_m2_reg  <= arc_delta(hue_q[HUE_W-1:0], cfg.sh_hue) * $signed({1'b0, cfg.sh_str});
            e_ls_reg  <= ls_full[32:16];
        end
    end

    // stage F: weighted products, lightness envelope
    spu_pay_t           f_pay_reg;
    logic [HUE_W-1:0]   f_hue_reg;
    logic signed [48:0] f_p1_reg, f_p2_reg;
    logic signed [19:0] f_q_reg, f_p_reg;
    logic [17:0]        w_inv;
    logic signed [19:0] q_raw, p_raw, p_cl, q_cl;

    always_comb
    begin
        w_inv = 18'(18'd65536 - {1'b0, e_pay_reg.weight});
        if (e_pay_reg.light < 16'd32768)
            q_raw = $signed({4'b0, e_pay_reg.light}) + $signed({3'b0, e_ls_reg});
        else
            q_raw = $signed({4'b0, e_pay_reg.light}) + $signed({3'b0, e_s16_reg})
                  - $signed({3'b0, e_ls_reg});
        p_raw = $signed({3'b0, e_pay_reg.light, 1'b0}) - q_raw;
        p_cl  = (p_raw < 0) ? 20'sd0 : p_raw;
        q_cl  = (q_raw < p_cl) ? p_cl : q_raw;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_pay_reg <= e_pay_reg;
            f_hue_reg <= e_hue_reg;
            f_p1_reg  <= e_m1_reg * $signed({1'b0, e_pay_reg.weight});
            f_p2_reg  <= e_m2_reg * $signed(w_inv);
            f_q_reg   <= q_cl;
            f_p_reg   <= p_cl;
        end
    end

    // stage G: hue shift
    spu_pay_t           g_pay_reg;
    logic [HUE_W-1:0]   g_h_reg;
    logic [17:0]        g_q_reg, g_p_reg;
    logic signed [49:0] shift;

    assign shift = rnd_shift(50'(f_p1_reg) + 50'(f_p2_reg), GAIN_W - 1 + 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_pay_reg <= f_pay_reg;
            g_h_reg   <= f_hue_reg + shift[HUE_W-1:0];
            g_q_reg   <= f_q_reg[17:0];
            g_p_reg   <= f_p_reg[17:0];
        end
    end

    // stage H: sector select per channel
    spu_pay_t         h_pay_reg;
    logic [17:0]      h_span_reg, h_q_reg, h_p_reg;
    spu_sel_t         h_sel_reg [3];
    logic [16:0]      h_f_reg   [3];
    logic [HUE_W-1:0] tch [3];
    spu_sel_t         sel [3];
    logic [16:0]      fct [3];
    logic [18:0]      six;

    always_comb
    begin
        tch[0] = g_h_reg + THIRD_TURN;
        tch[1] = g_h_reg;
        tch[2] = g_h_reg - THIRD_TURN;
        six    = '0;
        for (int i = 0; i < 3; i++)
        begin
            six = {3'b0, tch[i]} * 19'd6;
            if (six < 19'd65536)
            begin
                sel[i] = SEL_RAMP;
                fct[i] = six[16:0];
            end
            else if (tch[i] < 16'd32768)
            begin
                sel[i] = SEL_Q;
                fct[i] = '0;
            end
            else if (({2'b0, tch[i]} * 18'd3) < 18'd131072)
            begin
                sel[i] = SEL_RAMP;
                fct[i] = 17'(19'd262144 - six);
            end
            else
            begin
                sel[i] = SEL_P;
                fct[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_pay_reg  <= g_pay_reg;
            h_span_reg <= g_q_reg - g_p_reg;
            h_q_reg    <= g_q_reg;
            h_p_reg    <= g_p_reg;
            for (int i = 0; i < 3; i++)
            begin
                h_sel_reg[i] <= sel[i];
                h_f_reg[i]   <= fct[i];
            end
        end
    end

    // stage I: ramp evaluation
    spu_pay_t    i_pay_reg;
    logic [18:0] i_res_reg [3];
    logic [18:0] res [3];
    logic [35:0] rp  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rp[i] = (36'(h_span_reg) * 36'(h_f_reg[i])) + 36'd32768;
            if (h_pay_reg.gray)
                res[i] = 19'(h_pay_reg.light);
            else
            begin
                unique case (h_sel_reg[i])
                    SEL_RAMP: res[i] = 19'(h_p_reg) + 19'(rp[i][35:16]);
                    SEL_Q:    res[i] = 19'(h_q_reg);
                    SEL_P:    res[i] = 19'(h_p_reg);
                    default:  res[i] = 19'(h_p_reg);
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_pay_reg <= h_pay_reg;
            for (int i = 0; i < 3; i++)
                i_res_reg[i] <= res[i];
        end
    end

    // stage J: blend with original and saturate
    logic [PIX_W-1:0]   orig [3];
    logic [PIX_W-1:0]   outc [3];
    logic signed [19:0] dif  [3];
    logic signed [49:0] adj  [3];
    logic signed [22:0] v    [3];

    always_comb
    begin
        orig[0] = i_pay_reg.red;
        orig[1] = i_pay_reg.green;
        orig[2] = i_pay_reg.blue;
        for (int i = 0; i < 3; i++)
        begin
            dif[i] = $signed({1'b0, i_res_reg[i]}) - $signed({4'b0, orig[i]});
            adj[i] = rnd_shift(50'($signed({1'b0, cfg.mix}) * dif[i]), GAIN_W - 1);
            v[i]   = $signed({7'b0, orig[i]}) + adj[i][22:0];
            if (v[i] < 0)
                outc[i] = '0;
            else if (v[i] > 23'sd65535)
                outc[i] = '1;
            else
                outc[i] = v[i][PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red   <= outc[0];
            green <= outc[1];
            blue  <= outc[2];
            alpha <= i_pay_reg.alpha;
        end
    end

endmodule
`default_nettype wire

[src/split_tone_pixel_unit.sv]
// Split tone pixel unit: top level with config registers, valid chain and stages.
// Depends on spu_pkg, spu_front, spu_div, spu_back and the macros header.
//
// Split toning of an RGBA stream, one pixel word per clock. Each pixel gets
// its Rec.709 luma, a smoothstep highlight weight around a pivot moved by
// balance, and an HSL hue that is pulled toward the highlight and shadow
// hues; the toned color is blended with the original by mix and alpha is
// passed along. From input accept to output valid, a word passes through
// 4 front stages (luma, weight, HSL prep), 17 divider stages (one quotient
// bit per stage for hue and saturation, run side by side) and 6 back stages.
// Throughput is one word per cycle; the whole pipe holds when the output
// word is not taken. Config writes take effect on the next accepted word and
// must only be issued while the pipe is empty.
`default_nettype none
`include "split_tone_pixel_unit_macros.svh"
module split_tone_pixel_unit import spu_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input pixel stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_W-1:0]     s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
    // output pixel stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WORD_W-1:0]     m_axis_tdata   // red_out, green_out, blue_out, alpha_out
);

    // config registers
    logic [HUE_W-1:0]  hl_hue_reg, sh_hue_reg;
    logic [GAIN_W-1:0] hl_str_reg, sh_str_reg, mix_reg;
    logic [BAL_W-1:0]  balance_reg;
    logic [PIX_W-1:0]  pivot_reg, pivot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_hue_reg  <= HL_HUE_RST;
            hl_str_reg  <= '0;
            sh_hue_reg  <= SH_HUE_RST;
            sh_str_reg  <= '0;
            balance_reg <= '0;
            mix_reg     <= GAIN_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_HL_HUE:  hl_hue_reg  <= cfg_wdata[HUE_W-1:0];
                CFG_HL_STR:  hl_str_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_SH_HUE:  sh_hue_reg  <= cfg_wdata[HUE_W-1:0];
                CFG_SH_STR:  sh_str_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_BALANCE: balance_reg <= cfg_wdata[BAL_W-1:0];
                CFG_MIX:     mix_reg     <= cfg_wdata[GAIN_W-1:0];
                default:     ;
            endcase
        end
    end

    // luma pivot, derived from balance and held in a register
    logic signed [49:0] bal_shift;
    logic signed [19:0] pivot_raw;

    always_comb
    begin
        bal_shift = rnd_shift(50'($signed(balance_reg) * $signed({1'b0, BAL_SCALE})),
                              GAIN_W - 1);
        pivot_raw = $signed({4'b0, PIVOT_MID}) - bal_shift[19:0];
        if (pivot_raw < $signed({4'b0, PIVOT_MIN}))
            pivot_next = PIVOT_MIN;
        else if (pivot_raw > $signed({4'b0, PIVOT_MAX}))
            pivot_next = PIVOT_MAX;
        else
            pivot_next = pivot_raw[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pivot_reg <= PIVOT_MID;
        else
            pivot_reg <= pivot_next;
    end

    // pipe advance: every stage moves unless the output word is stuck
    logic                adv;
    logic [PIPE_LAT-1:0] vld_reg;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
    end

    // front stages
    spu_pay_t   front_pay;
    spu_divop_t hue_op, sat_op;

    spu_front u_front (
        .clk    (clk),
        .en     (adv),
        .pivot  (pivot_reg),
        .red    (s_axis_tdata[PIX_W-1:0]),
        .green  (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .blue   (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .alpha  (s_axis_tdata[4*PIX_W-1:3*PIX_W]),
        .pay    (front_pay),
        .hue_op (hue_op),
        .sat_op (sat_op)
    );

    // hue and saturation dividers, side by side
    logic [DIV_QW-1:0] hue_q, sat_q;

    spu_div u_div_hue (
        .clk (clk),
        .en  (adv),
        .op  (hue_op),
        .quo (hue_q)
    );

    spu_div u_div_sat (
        .clk (clk),
        .en  (adv),
        .op  (sat_op),
        .quo (sat_q)
    );

    // payload rides alongside the dividers
    spu_pay_t pay_dly_reg [DIV_QW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_dly_reg[0] <= front_pay;
            for (int k = 1; k < DIV_QW; k++)
                pay_dly_reg[k] <= pay_dly_reg[k-1];
        end
    end

    // back stages
    spu_cfg_t back_cfg;

    always_comb
    begin
        back_cfg.hl_hue = hl_hue_reg;
        back_cfg.hl_str = hl_str_reg;
        back_cfg.sh_hue = sh_hue_reg;
        back_cfg.sh_str = sh_str_reg;
        back_cfg.mix    = mix_reg;
    end

    spu_back u_back (
        .clk   (clk),
        .en    (adv),
        .cfg   (back_cfg),
        .pay   (pay_dly_reg[DIV_QW-1]),
        .hue_q (hue_q),
        .sat_q (sat_q),
        .red   (m_axis_tdata[PIX_W-1:0]),
        .green (m_axis_tdata[2*PIX_W-1:PIX_W]),
        .blue  (m_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .alpha (m_axis_tdata[4*PIX_W-1:3*PIX_W])
    );

    // checks
    `SPU_ASSERT_ANY(a_rst_empty, !rst_n |-> !m_axis_tvalid, "output valid during reset")
    `SPU_ASSERT(a_stall_holds_in, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready,
        "input taken while output stalled")
    `SPU_ASSERT(a_pivot_range, (pivot_reg >= PIVOT_MIN) && (pivot_reg <= PIVOT_MAX),
        "pivot outside clamp range")
    `SPU_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> vld_reg[0],
        "accepted word missing from first stage")

endmodule
`default_nettype wire
